FILE: hdl/mfb_pkg.sv
// Package for the monochrome frame-store rectangle fill unit.
// Panel geometry, store sizing, command and status codes, shared-unit op codes and the
// store request struct. No dependencies.
`default_nettype none

package mfb_pkg;

    // Panel geometry in physical pixels
    localparam int PANEL_WIDTH  = 144;
    localparam int PANEL_HEIGHT = 168;

    // Store sizing: one byte per 8 pixels, LSB first
    localparam int ROW_BYTES   = (PANEL_WIDTH + 7) / 8;
    localparam int STORE_DEPTH = ROW_BYTES * PANEL_HEIGHT;
    localparam int AW          = (STORE_DEPTH > 2) ? $clog2(STORE_DEPTH) : 1;
    localparam int RA_W        = 12;
    localparam int XW          = (AW > RA_W) ? AW : RA_W;

    // Coordinate width: holds any panel coordinate and x + w - 1 of 8-bit fields
    localparam int CW = 11;
    // Byte-column width
    localparam int BCW = CW - 3;

    // Command codes (tuser)
    localparam logic CMD_FILL = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Result status codes
    localparam logic ST_DONE   = 1'b0;
    localparam logic ST_REJECT = 1'b1;

    // Rotation register values
    localparam logic [1:0] ROT_NONE = 2'd0;
    localparam logic [1:0] ROT_270  = 2'd1;
    localparam logic [1:0] ROT_180  = 2'd2;
    localparam logic [1:0] ROT_90   = 2'd3;

    // Register index, decoded from paddr[2]
    localparam logic REG_ROTATION = 1'b0;

    // Shared coordinate unit operations
    typedef enum logic [1:0] {
        ALU_PASS   = 2'd0,   // a
        ALU_END    = 2'd1,   // a + b - 1
        ALU_MIRROR = 2'd2    // a - 1 - b
    } t_alu_op;

    // Request from the sequencer to the frame store
    typedef struct packed {
        logic          rd;    // plain byte read
        logic          rmw;   // read-modify-write of a byte
        logic [AW-1:0] addr;
        logic [7:0]    mask;
        logic          on;    // 1 sets masked bits, 0 clears them
    } t_store_req;

endpackage

`default_nettype wire

FILE: hdl/mfb_alu.sv
// Shared coordinate unit: one add/subtract used for the rectangle end and rotated bound steps.
// Depends on mfb_pkg.
`default_nettype none

module mfb_alu (
    input  wire mfb_pkg::t_alu_op       i_op,
    input  wire logic [mfb_pkg::CW-1:0] i_a,
    input  wire logic [mfb_pkg::CW-1:0] i_b,
    output logic      [mfb_pkg::CW-1:0] o_y
);

    logic [mfb_pkg::CW-1:0] one;

    assign one = mfb_pkg::CW'(1);

    // One adder path, operand b negated for the mirror case
    always_comb begin
        unique case (i_op)
            mfb_pkg::ALU_END:    o_y = i_a + i_b - one;
            mfb_pkg::ALU_MIRROR: o_y = i_a - one - i_b;
            default:             o_y = i_a;
        endcase
    end

endmodule

`default_nettype wire

FILE: hdl/mfb_store.sv
// Frame store: one-byte-wide memory with registered read, pipelined
// read-modify-write and a clearing pass to all ones after reset.
// Depends on mfb_pkg.
`default_nettype none

module mfb_store (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire mfb_pkg::t_store_req i_req,
    output logic [7:0]               o_rdata,
    output logic                     o_busy
);

    logic [7:0] r_mem [mfb_pkg::STORE_DEPTH];

    logic [mfb_pkg::AW-1:0] r_clr_addr;
    logic                   r_clr_busy;
    logic [7:0]             r_rdata;

    // Pending write half of a read-modify-write
    logic                   r_pend;
    logic [mfb_pkg::AW-1:0] r_paddr;
    logic [7:0]             r_pmask;
    logic                   r_pon;

    logic [7:0] wr_data;

    assign wr_data = r_pon ? (r_rdata | r_pmask) : (r_rdata & ~r_pmask);

    // Clearing pass and pending-write control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_clr_busy <= 1'b1;
            r_pend     <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == mfb_pkg::AW'(mfb_pkg::STORE_DEPTH - 1)) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + mfb_pkg::AW'(1);
            end
            r_pend <= i_req.rmw;
        end
    end

    // Write-side payload for the pending beat
    always_ff @(posedge i_clk) begin
        r_paddr <= i_req.addr;
        r_pmask <= i_req.mask;
        r_pon   <= i_req.on;
    end

    // Memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= 8'hff;
        end else if (r_pend) begin
            r_mem[r_paddr] <= wr_data;
        end
        if (i_req.rd || i_req.rmw) begin
            r_rdata <= r_mem[i_req.addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_clr_busy;

endmodule

`default_nettype wire

FILE: hdl/mono_framebuffer_rect_fill_unit.sv
// Top level of the monochrome frame-store rectangle fill unit: stream ports,
// APB register, command sequencer. Depends on mfb_pkg, mfb_alu, mfb_store.
//
//  Channel   Ports             Beat contents (low bit first)
//  command   s_axis_*          tuser: cmd; tdata: pos_x, pos_y, rect_width,
//                              rect_height, colour, read_addr
//  result    m_axis_*          tdata: status, read_data
//  config    psel..prdata      register 0 at byte address 0: rotation
//
// A fill steps S_EX, S_EY, S_CHK, S_C0, S_C1, S_R0, S_R1, S_BASE, then S_WALK at
// one store byte per cycle (rows times byte columns), then S_FIN; a read goes S_RD, S_RDW,
// S_FIN. A rejected fill leaves at S_CHK, a rejected read at S_RD. The next beat is taken
// only in S_IDLE, entered as the result is registered; single store port and shared adder
// set this. After reset a clearing pass writes all ones, one byte a cycle, with commands
// held off. A waiting result holds the sequencer at its next result only.
`default_nettype none

module mono_framebuffer_rect_fill_unit (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Command stream
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [47:0] s_axis_tdata,  // pos_x, pos_y, rect_width, rect_height,
                                            // colour, read_addr, zero pad
    input  wire logic        s_axis_tuser,  // cmd
    // Result stream
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // status, read_data, zero pad
    // Configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int CW  = mfb_pkg::CW;
    localparam int AW  = mfb_pkg::AW;
    localparam int BCW = mfb_pkg::BCW;

    typedef enum logic [3:0] {
        S_IDLE, S_EX, S_EY, S_CHK, S_C0, S_C1, S_R0, S_R1,
        S_BASE, S_WALK, S_RD, S_RDW, S_FIN
    } t_state;

    t_state r_state;

    // Configuration register
    logic [1:0] r_rotation;

    // Latched command
    logic [CW-1:0] r_x, r_y, r_w, r_h;
    logic          r_colour;
    logic [11:0]   r_raddr;

    // Geometry
    logic [CW-1:0] r_ex, r_ey;
    logic [CW-1:0] r_c0, r_c1, r_r0, r_r1;
    logic [CW-1:0] r_row;
    logic [BCW-1:0] r_byte;
    logic [AW-1:0] r_base;

    // Result
    logic       r_status;
    logic [7:0] r_data;
    logic       r_ovalid;
    logic [15:0] r_odata;

    // Shared unit hookup
    mfb_pkg::t_alu_op alu_op;
    logic [CW-1:0]    alu_a, alu_b, alu_y;

    mfb_pkg::t_store_req req;
    logic [7:0]          st_rdata;
    logic                st_busy;

    logic [CW-1:0]  lw, lh, pw, ph;
    logic [BCW-1:0] b0, b1;
    logic [7:0]     mask_first, mask_last;
    logic           out_free;
    logic           in_beat;
    logic           rd_ok;

    function automatic logic XW_LT(input logic [11:0] a);
        logic [mfb_pkg::XW-1:0] ax;
        ax = mfb_pkg::XW'(a);
        return ax < mfb_pkg::XW'(mfb_pkg::STORE_DEPTH);
    endfunction

    assign pw = CW'(mfb_pkg::PANEL_WIDTH);
    assign ph = CW'(mfb_pkg::PANEL_HEIGHT);
    assign lw = r_rotation[0] ? ph : pw;
    assign lh = r_rotation[0] ? pw : ph;

    assign b0 = r_c0[CW-1:3];
    assign b1 = r_c1[CW-1:3];
    assign mask_first = 8'(8'hff << r_c0[2:0]);
    assign mask_last  = 8'hff >> (3'd7 - r_c1[2:0]);

    assign out_free = !r_ovalid || m_axis_tready;
    assign s_axis_tready = (r_state == S_IDLE) && !st_busy;
    assign in_beat = s_axis_tvalid && s_axis_tready;
    assign rd_ok = XW_LT(r_raddr);

    // APB port: always ready, register 0 only
    assign pready = 1'b1;
    assign prdata = {30'd0, r_rotation};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rotation <= mfb_pkg::ROT_NONE;
        end else if (psel && penable && pwrite && (paddr[2] == mfb_pkg::REG_ROTATION)) begin
            r_rotation <= pwdata[1:0];
        end
    end

    // Operand select for the shared unit, per sequencer step and rotation
    always_comb begin
        alu_op = mfb_pkg::ALU_PASS;
        alu_a  = r_x;
        alu_b  = r_w;
        unique case (r_state)
            S_EX: begin
                alu_op = mfb_pkg::ALU_END; alu_a = r_x; alu_b = r_w;
            end
            S_EY: begin
                alu_op = mfb_pkg::ALU_END; alu_a = r_y; alu_b = r_h;
            end
            S_C0: begin
                unique case (r_rotation)
                    mfb_pkg::ROT_NONE: begin alu_a = r_x; end
                    mfb_pkg::ROT_270: begin
                        alu_op = mfb_pkg::ALU_MIRROR; alu_a = pw; alu_b = r_ey;
                    end
                    mfb_pkg::ROT_180: begin
                        alu_op = mfb_pkg::ALU_MIRROR; alu_a = pw; alu_b = r_ex;
                    end
                    default: begin alu_a = r_y; end
                endcase
            end
            S_C1: begin
                unique case (r_rotation)
                    mfb_pkg::ROT_NONE: begin alu_a = r_ex; end
                    mfb_pkg::ROT_270: begin
                        alu_op = mfb_pkg::ALU_MIRROR; alu_a = pw; alu_b = r_y;
                    end
                    mfb_pkg::ROT_180: begin
                        alu_op = mfb_pkg::ALU_MIRROR; alu_a = pw; alu_b = r_x;
                    end
                    default: begin alu_a = r_ey; end
                endcase
            end
            S_R0: begin
                unique case (r_rotation)
                    mfb_pkg::ROT_NONE: begin alu_a = r_y; end
                    mfb_pkg::ROT_270:  begin alu_a = r_x; end
                    mfb_pkg::ROT_180: begin
                        alu_op = mfb_pkg::ALU_MIRROR; alu_a = ph; alu_b = r_ey;
                    end
                    default: begin
                        alu_op = mfb_pkg::ALU_MIRROR; alu_a = ph; alu_b = r_ex;
                    end
                endcase
            end
            S_R1: begin
                unique case (r_rotation)
                    mfb_pkg::ROT_NONE: begin alu_a = r_ey; end
                    mfb_pkg::ROT_270:  begin alu_a = r_ex; end
                    mfb_pkg::ROT_180: begin
                        alu_op = mfb_pkg::ALU_MIRROR; alu_a = ph; alu_b = r_y;
                    end
                    default: begin
                        alu_op = mfb_pkg::ALU_MIRROR; alu_a = ph; alu_b = r_x;
                    end
                endcase
            end
            default: begin
                alu_op = mfb_pkg::ALU_PASS;
            end
        endcase
    end

    mfb_alu u_alu (
        .i_op (alu_op),
        .i_a  (alu_a),
        .i_b  (alu_b),
        .o_y  (alu_y)
    );

    // Store requests: one byte per cycle while walking, single read for reads
    always_comb begin
        req.rd   = (r_state == S_RD) && rd_ok;
        req.rmw  = (r_state == S_WALK);
        req.addr = (r_state == S_RD) ? AW'(r_raddr) : (r_base + AW'(r_byte));
        req.mask = ((r_byte == b0) ? mask_first : 8'hff) & ((r_byte == b1) ? mask_last : 8'hff);
        req.on   = r_colour;
    end

    mfb_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rdata (st_rdata),
        .o_busy  (st_busy)
    );

    // Command latch
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_x      <= CW'(s_axis_tdata[7:0]);
            r_y      <= CW'(s_axis_tdata[15:8]);
            r_w      <= CW'(s_axis_tdata[23:16]);
            r_h      <= CW'(s_axis_tdata[31:24]);
            r_colour <= s_axis_tdata[32];
            r_raddr  <= s_axis_tdata[44:33];
        end
    end

    // Sequencer with result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            // Result valid: set on a finished command, cleared once taken
            if ((r_state == S_FIN) && out_free) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_status <= mfb_pkg::ST_DONE;
                    r_data   <= 8'd0;
                    if (in_beat) begin
                        r_state <= (s_axis_tuser == mfb_pkg::CMD_FILL) ? S_EX : S_RD;
                    end
                end
                S_EX: begin
                    r_ex    <= alu_y;
                    r_state <= S_EY;
                end
                S_EY: begin
                    r_ey    <= alu_y;
                    r_state <= S_CHK;
                end
                S_CHK: begin
                    // Empty rectangles and ones that reach past the panel edge are rejected whole
                    if ((r_w == '0) || (r_h == '0) || (r_ex >= lw) || (r_ey >= lh)) begin
                        r_status <= mfb_pkg::ST_REJECT;
                        r_state  <= S_FIN;
                    end else begin
                        r_state <= S_C0;
                    end
                end
                S_C0: begin
                    r_c0    <= alu_y;
                    r_state <= S_C1;
                end
                S_C1: begin
                    r_c1    <= alu_y;
                    r_state <= S_R0;
                end
                S_R0: begin
                    r_r0    <= alu_y;
                    r_state <= S_R1;
                end
                S_R1: begin
                    r_r1    <= alu_y;
                    r_state <= S_BASE;
                end
                S_BASE: begin
                    r_base  <= AW'(r_r0 * mfb_pkg::ROW_BYTES);
                    r_row   <= r_r0;
                    r_byte  <= b0;
                    r_state <= S_WALK;
                end
                S_WALK: begin
                    // Step along the row, then to the next row
                    if (r_byte == b1) begin
                        if (r_row == r_r1) begin
                            r_state <= S_FIN;
                        end else begin
                            r_row  <= r_row + CW'(1);
                            r_base <= r_base + AW'(mfb_pkg::ROW_BYTES);
                            r_byte <= b0;
                        end
                    end else begin
                        r_byte <= r_byte + BCW'(1);
                    end
                end
                S_RD: begin
                    if (rd_ok) begin
                        r_state <= S_RDW;
                    end else begin
                        r_status <= mfb_pkg::ST_REJECT;
                        r_state  <= S_FIN;
                    end
                end
                S_RDW: begin
                    r_data  <= st_rdata;
                    r_state <= S_FIN;
                end
                S_FIN: begin
                    if (out_free) begin
                        r_odata  <= {7'd0, r_data, r_status};
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
// Self-checking bench for the monochrome frame-store rectangle fill unit.
// Predicts every result beat from a shadow copy of the store and the rotation register.
// Depends on mfb_pkg and mono_framebuffer_rect_fill_unit.
`timescale 1ns / 100ps

module tb_top;

    // Geometry from the package
    localparam int PANEL_WIDTH  = mfb_pkg::PANEL_WIDTH;
    localparam int PANEL_HEIGHT = mfb_pkg::PANEL_HEIGHT;
    localparam int ROW_BYTES    = mfb_pkg::ROW_BYTES;
    localparam int STORE_DEPTH  = mfb_pkg::STORE_DEPTH;

    // Command and status codes
    localparam logic       CMD_FILL      = mfb_pkg::CMD_FILL;
    localparam logic       CMD_READ      = mfb_pkg::CMD_READ;
    localparam logic       ST_REJECT     = mfb_pkg::ST_REJECT;
    localparam logic [1:0] ROT_NONE      = mfb_pkg::ROT_NONE;
    localparam logic [1:0] ROT_270       = mfb_pkg::ROT_270;
    localparam logic [1:0] ROT_180       = mfb_pkg::ROT_180;
    localparam logic [1:0] ROT_90        = mfb_pkg::ROT_90;
    localparam logic [2:0] ADDR_ROTATION = {mfb_pkg::REG_ROTATION, 2'b00};

    localparam int HOLD_CYCLES   = 400;
    localparam int TAIL_CYCLES   = STORE_DEPTH + 64;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_BEATS   = 25;
    localparam longint LIMIT_NS  = 64'd10_000_000;

    // Command beat payload, pos_x in the lowest bits
    typedef struct packed {
        logic [2:0]  pad;
        logic [11:0] read_addr;
        logic        colour;
        logic [7:0]  rect_height;
        logic [7:0]  rect_width;
        logic [7:0]  pos_y;
        logic [7:0]  pos_x;
    } t_cmd_word;

    // Result beat payload, status in bit 0
    typedef struct packed {
        logic [6:0] pad;
        logic [7:0] read_data;
        logic       status;
    } t_cmd_result;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata  = '0;
    logic        s_axis_tuser  = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;

    mono_framebuffer_rect_fill_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // Shadow state
    logic [7:0]  shadow_frame [STORE_DEPTH];
    logic [1:0]  rot_shadow = ROT_NONE;
    int          last_touched = 0;
    t_cmd_result pending_results [$];
    int unsigned mismatches = 0;
    int          burst_left = 0;
    bit          hold_off_req = 1'b0;
    bit          hold_active  = 1'b0;

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic int logical_width();
        return rot_shadow[0] ? PANEL_HEIGHT : PANEL_WIDTH;
    endfunction

    function automatic int logical_height();
        return rot_shadow[0] ? PANEL_WIDTH : PANEL_HEIGHT;
    endfunction

    // Predicts one result and updates the shadow store
    function automatic t_cmd_result apply_command(input logic cmd, input t_cmd_word w);
        t_cmd_result r;
        int          x, y, cw, ch, lw, lh, c0, c1, r0, r1, idx;
        logic [7:0]  m;
        r = '0;
        if (cmd == CMD_READ) begin
            if (w.read_addr < STORE_DEPTH) r.read_data = shadow_frame[w.read_addr];
            else r.status = ST_REJECT;
            return r;
        end
        x  = w.pos_x;
        y  = w.pos_y;
        cw = w.rect_width;
        ch = w.rect_height;
        lw = logical_width();
        lh = logical_height();
        // empty or off-panel rectangles draw nothing
        if (cw == 0 || ch == 0 || x >= lw || y >= lh || x + cw > lw || y + ch > lh) begin
            r.status = ST_REJECT;
            return r;
        end
        case (rot_shadow)
            ROT_270: begin
                c0 = PANEL_WIDTH - y - ch;  c1 = PANEL_WIDTH - 1 - y;
                r0 = x;                     r1 = x + cw - 1;
            end
            ROT_180: begin
                c0 = PANEL_WIDTH - x - cw;  c1 = PANEL_WIDTH - 1 - x;
                r0 = PANEL_HEIGHT - y - ch; r1 = PANEL_HEIGHT - 1 - y;
            end
            ROT_90: begin
                c0 = y;                     c1 = y + ch - 1;
                r0 = PANEL_HEIGHT - x - cw; r1 = PANEL_HEIGHT - 1 - x;
            end
            default: begin
                c0 = x;                     c1 = x + cw - 1;
                r0 = y;                     r1 = y + ch - 1;
            end
        endcase
        // edge masks on the first and last byte of each row
        for (int row = r0; row <= r1; row++) begin
            for (int b = c0 >> 3; b <= (c1 >> 3); b++) begin
                m = 8'hff;
                if (b == (c0 >> 3)) m = m & (8'hff << (c0 & 7));
                if (b == (c1 >> 3)) m = m & (8'hff >> (7 - (c1 & 7)));
                idx = row * ROW_BYTES + b;
                last_touched = idx;
                if (w.colour) shadow_frame[idx] = shadow_frame[idx] | m;
                else shadow_frame[idx] = shadow_frame[idx] & ~m;
            end
        end
        return r;
    endfunction

    function automatic t_cmd_word make_fill(input int x, input int y, input int cw,
                                            input int ch, input logic colour);
        t_cmd_word w;
        w = '0;
        w.pos_x       = x[7:0];
        w.pos_y       = y[7:0];
        w.rect_width  = cw[7:0];
        w.rect_height = ch[7:0];
        w.colour      = colour;
        w.read_addr   = 12'($urandom);
        return w;
    endfunction

    // Unused fields are randomized
    function automatic t_cmd_word make_read(input int addr);
        t_cmd_word w;
        w = t_cmd_word'(48'({$urandom, $urandom}));
        w.pad       = '0;
        w.read_addr = addr[11:0];
        return w;
    endfunction

    // Sends one command beat; bursts of random length with random gaps
    task automatic send_beat(input logic cmd, input t_cmd_word w);
        int gap;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            repeat (gap) begin
                @(negedge i_clk);
                s_axis_tvalid <= 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= w;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_results.push_back(apply_command(cmd, w));
    endtask

    // Sender pauses until every result has come back
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of the rotation register, then read back
    task automatic write_rotation(input logic [1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ROTATION;
        pwdata  <= {30'd0, value};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        rot_shadow = value;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[1:0] != rot_shadow) begin
            $display("%0t rotation readback: expected %0d actual %0d",
                     $realtime, rot_shadow, prdata[1:0]);
            mismatches++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Store contents after the clearing pass, reads past the store
    task automatic test_reset_state();
        send_beat(CMD_READ, make_read(0));
        send_beat(CMD_READ, make_read(STORE_DEPTH - 1));
        send_beat(CMD_READ, make_read(STORE_DEPTH));
        send_beat(CMD_READ, make_read(4095));
        wait_drained();
    endtask

    // Unrotated corners, partial-byte masks and rejected rectangles
    task automatic test_fill_edges();
        send_beat(CMD_FILL, make_fill(0, 0, PANEL_WIDTH, PANEL_HEIGHT, 1'b0));
        send_beat(CMD_FILL, make_fill(0, 0, 1, 1, 1'b1));
        send_beat(CMD_READ, make_read(0));
        send_beat(CMD_FILL, make_fill(PANEL_WIDTH - 1, PANEL_HEIGHT - 1, 1, 1, 1'b1));
        send_beat(CMD_READ, make_read(STORE_DEPTH - 1));
        send_beat(CMD_FILL, make_fill(3, 5, 10, 2, 1'b1));
        send_beat(CMD_READ, make_read(5 * ROW_BYTES));
        send_beat(CMD_READ, make_read(5 * ROW_BYTES + 1));
        // zero size
        send_beat(CMD_FILL, make_fill(0, 0, 0, 5, 1'b1));
        send_beat(CMD_FILL, make_fill(0, 0, 5, 0, 1'b1));
        // far edge and origin off the panel
        send_beat(CMD_FILL, make_fill(PANEL_WIDTH - 4, 0, 5, 1, 1'b1));
        send_beat(CMD_FILL, make_fill(PANEL_WIDTH, 0, 1, 1, 1'b1));
        send_beat(CMD_FILL, make_fill(0, PANEL_HEIGHT, 1, 1, 1'b1));
        send_beat(CMD_FILL, make_fill(255, 255, 255, 255, 1'b1));
        wait_drained();
    endtask

    // One edge fill and one over-the-edge reject per rotated setting
    task automatic test_rotations();
        logic [1:0] rots [3];
        rots = '{ROT_270, ROT_180, ROT_90};
        foreach (rots[i]) begin
            write_rotation(rots[i]);
            send_beat(CMD_FILL, make_fill(logical_width() - 3, 0, 3, 2, 1'b1));
            send_beat(CMD_READ, make_read(last_touched));
            send_beat(CMD_FILL, make_fill(logical_width() - 8, 1, 9, 1, 1'b1));
            wait_drained();
        end
    endtask

    // Long receiver hold-off while the sender keeps offering beats
    task automatic test_backpressure();
        hold_off_req = 1'b1;
        wait (hold_active);
        burst_left = 16;
        for (int i = 0; i < 12; i++) begin
            if (i % 3 == 0) send_beat(CMD_FILL, make_fill(i, i, 4, 3, i[0]));
            else send_beat(CMD_READ, make_read($urandom_range(0, STORE_DEPTH - 1)));
        end
        wait_drained();
    endtask

    // Random phases, each under its own rotation setting
    task automatic test_random();
        logic [1:0] rot_seq [RANDOM_PHASES];
        int         sel, lw, lh, cw, ch, addr;
        rot_seq = '{ROT_NONE, ROT_90, ROT_270, ROT_180, 2'($urandom), 2'($urandom)};
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            write_rotation(rot_seq[p]);
            lw = logical_width();
            lh = logical_height();
            for (int n = 0; n < PHASE_BEATS; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 49) begin
                    // well-formed rectangle, mostly small
                    if (sel < 45) begin
                        cw = $urandom_range(1, 24);
                        ch = $urandom_range(1, 8);
                    end else begin
                        cw = $urandom_range(1, lw);
                        ch = $urandom_range(1, lh);
                    end
                    send_beat(CMD_FILL, make_fill($urandom_range(0, lw - cw),
                                                  $urandom_range(0, lh - ch),
                                                  cw, ch, 1'($urandom)));
                end else if (sel < 85) begin
                    // reads mostly near the last painted byte
                    if ($urandom_range(0, 4) < 3) begin
                        addr = last_touched + $urandom_range(0, 2 * ROW_BYTES) - ROW_BYTES;
                        if (addr < 0) addr = 0;
                    end else begin
                        addr = $urandom_range(0, STORE_DEPTH - 1);
                    end
                    send_beat(CMD_READ, make_read(addr));
                end else begin
                    // noise across the full field ranges
                    send_beat(1'($urandom), make_read($urandom_range(0, 4095)));
                end
            end
            wait_drained();
        end
    endtask

    // Result sink: random ready pattern, free-running stretches, long hold on request
    always begin : result_sink
        int on_len, off_len;
        if (hold_off_req) begin
            hold_active = 1'b1;
            repeat (HOLD_CYCLES) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
            hold_active  = 1'b0;
            hold_off_req = 1'b0;
        end else begin
            if ($urandom_range(0, 3) == 0) begin
                on_len  = $urandom_range(20, 60);
                off_len = 0;
            end else begin
                on_len  = $urandom_range(1, 6);
                off_len = $urandom_range(1, 5);
            end
            repeat (on_len) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b1;
            end
            repeat (off_len) begin
                @(negedge i_clk);
                m_axis_tready <= 1'b0;
            end
        end
    end

    // Compare each result beat with the oldest prediction
    always @(posedge i_clk) begin : result_check
        t_cmd_result got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata;
            if (pending_results.size() == 0) begin
                $display("%0t unexpected beat: expected none actual status %0d data %02h",
                         $realtime, got.status, got.read_data);
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t status: expected %0d actual %0d",
                             $realtime, want.status, got.status);
                    mismatches++;
                end
                if (got.read_data !== want.read_data) begin
                    $display("%0t read_data: expected %02h actual %02h",
                             $realtime, want.read_data, got.read_data);
                    mismatches++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #LIMIT_NS;
        $display("mono_framebuffer_rect_fill_unit: mismatch");
        $finish;
    end

    initial begin
        foreach (shadow_frame[i]) shadow_frame[i] = 8'hff;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        write_rotation(ROT_NONE);
        test_reset_state();
        test_fill_edges();
        test_rotations();
        test_backpressure();
        test_random();
        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("mono_framebuffer_rect_fill_unit: match");
        end else begin
            $display("mono_framebuffer_rect_fill_unit: mismatch");
        end
        $finish;
    end

endmodule

FILE: sim.f
hdl/mfb_pkg.sv
hdl/mfb_alu.sv
hdl/mfb_store.sv
hdl/mono_framebuffer_rect_fill_unit.sv
sim/tb_top.sv
